FILE: rtl/core/dpt_pkg.sv
package dpt_pkg;

  localparam int MaxEntries = 16;
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW       = $clog2(MaxEntries + 1);

  localparam logic [15:0] CmdAnnounce = 16'h0000;
  localparam logic [15:0] CmdGetPid   = 16'h1181;

  localparam logic [31:0] StaleTimeoutRst  = 32'd5000;
  localparam logic [31:0] RetryIntervalRst = 32'd500;

  // configuration register indexes
  localparam logic RegStaleTimeout  = 1'b0;
  localparam logic RegRetryInterval = 1'b1;

  typedef enum logic [2:0] {
    EvNone      = 3'd0,
    EvRefreshed = 3'd1,
    EvAdded     = 3'd2,
    EvFull      = 3'd3,
    EvPid       = 3'd4,
    EvRequest   = 3'd5
  } dpt_event_e;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic [7:0]  frame_crc_low;
    logic [7:0]  frame_len;
    logic [63:0] device_id;
    logic [7:0]  svc_idx;
    logic [15:0] command;
    logic [31:0] product_id;
    logic        rx_busy;
  } dpt_in_t;

  typedef struct packed {
    logic        request_valid;
    logic [63:0] target_id;
    logic [2:0]  event_res;
    logic [4:0]  device_count;
  } dpt_out_t;

  typedef struct packed {
    logic [63:0] id;
    logic [31:0] product_id;
    logic [31:0] last_seen;
    logic [31:0] last_request;
    logic        pid_known;
  } dpt_entry_t;

  // per-entry verdict from the head cell
  typedef struct packed {
    logic        hit;
    logic        append;
    logic        announce;
    logic        request;
    dpt_event_e  ev;
    logic [63:0] target;
  } dpt_head_res_t;

endpackage

FILE: rtl/core/dpt_cell.sv
module dpt_cell (
  input  logic               clk_i,
  input  logic               shift_i,
  input  dpt_pkg::dpt_entry_t entry_i,
  output dpt_pkg::dpt_entry_t entry_o
);
  import dpt_pkg::*;

  dpt_entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/core/dpt_head.sv
module dpt_head (
  input  dpt_pkg::dpt_in_t      item_i,
  input  dpt_pkg::dpt_entry_t   entry_i,
  input  logic [dpt_pkg::IdxW-1:0] idx_i,
  input  logic [dpt_pkg::CntW-1:0] count_i,
  input  logic                  found_i,
  input  logic [31:0]           stale_timeout_i,
  input  logic [31:0]           retry_interval_i,
  output dpt_pkg::dpt_entry_t   entry_o,
  output dpt_pkg::dpt_head_res_t res_o
);
  import dpt_pkg::*;

  logic        in_use;
  logic        at_tail;
  logic        frame_ok;
  logic        announce;
  logic        pid_reply;
  logic        poll;
  logic        id_hit;
  logic [31:0] seen_age;
  logic [31:0] req_age;
  logic        eligible;

  assign in_use    = CntW'(idx_i) < count_i;
  assign at_tail   = CntW'(idx_i) == count_i;
  assign frame_ok  = !item_i.action && !(item_i.frame_crc_low == 8'd0 &&
                     item_i.frame_len == 8'd0) && item_i.svc_idx == 8'd0;
  assign announce  = frame_ok && item_i.command == CmdAnnounce && item_i.device_id != 64'd0;
  assign pid_reply = frame_ok && item_i.command == CmdGetPid;
  assign poll      = item_i.action && !item_i.rx_busy;
  assign id_hit    = in_use && !found_i && entry_i.id == item_i.device_id;

  // wraparound ages
  assign seen_age  = item_i.now_ms - entry_i.last_seen;
  assign req_age   = item_i.now_ms - entry_i.last_request;
  assign eligible  = in_use && !found_i && !entry_i.pid_known &&
                     seen_age <= stale_timeout_i && req_age >= retry_interval_i;

  always_comb begin
    entry_o           = entry_i;
    res_o.hit         = 1'b0;
    res_o.append      = 1'b0;
    res_o.announce    = announce;
    res_o.request     = 1'b0;
    res_o.ev          = EvNone;
    res_o.target      = 64'd0;
    priority if (announce && id_hit) begin
      entry_o.last_seen = item_i.now_ms;
      res_o.hit         = 1'b1;
      res_o.ev          = EvRefreshed;
    end else if (announce && !found_i && at_tail) begin
      entry_o.id           = item_i.device_id;
      entry_o.product_id   = 32'd0;
      entry_o.last_seen    = item_i.now_ms;
      entry_o.last_request = 32'd0;
      entry_o.pid_known    = 1'b0;
      res_o.hit            = 1'b1;
      res_o.append         = 1'b1;
      res_o.ev             = EvAdded;
    end else if (pid_reply && id_hit) begin
      entry_o.product_id = item_i.product_id;
      entry_o.pid_known  = 1'b1;
      entry_o.last_seen  = item_i.now_ms;
      res_o.hit          = 1'b1;
      res_o.ev           = EvPid;
    end else if (poll && eligible) begin
      entry_o.last_request = item_i.now_ms;
      res_o.hit            = 1'b1;
      res_o.request        = 1'b1;
      res_o.ev             = EvRequest;
      res_o.target         = entry_i.id;
    end else begin
      // entry passes through unchanged
      entry_o = entry_i;
    end
  end

endmodule

FILE: rtl/core/device_presence_table_unit.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o  | dpt_in_t  in_item_i
// out     | output    | out_valid_o / out_stall_i | dpt_out_t out_item_o
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// an accepted item's scan rotates the entry ring once past the head cell (one entry
// per cycle, MaxEntries entries), then its result is loaded into the output register.
// the next item is accepted only after that load, so items do not overlap.
// reset clears the entry count and the handshake state and loads the config registers
// with their reset values; entry contents stay undefined until appended. a stalled output
// holds the result and the block waits with the finished scan until the output register is free.
module device_presence_table_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dpt_pkg::dpt_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dpt_pkg::dpt_out_t out_item_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);
  import dpt_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic            found_q, found_d;
  dpt_event_e      ev_q, ev_d;
  logic            req_q, req_d;
  logic [63:0]     target_q, target_d;
  logic [31:0]     stale_q, retry_q;
  dpt_in_t         item_q;
  logic            out_valid_q, out_valid_d;
  dpt_out_t        out_q, out_d;

  dpt_entry_t      ring [MaxEntries];
  dpt_entry_t      head_entry;
  dpt_head_res_t   head_res;
  logic            shift;
  logic            in_acc;
  logic            out_free;
  dpt_event_e      final_ev;

  assign shift    = state_q == StScan;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // ring of entry cells; cell 0 feeds the head, the head refills the last cell
  for (genvar k = 0; k < MaxEntries; k++) begin : g_cell
    dpt_entry_t feed;
    if (k == MaxEntries - 1) begin : g_last
      assign feed = head_entry;
    end else begin : g_mid
      assign feed = ring[k+1];
    end
    dpt_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .entry_i(feed),
      .entry_o(ring[k])
    );
  end

  dpt_head u_head (
    .item_i          (item_q),
    .entry_i         (ring[0]),
    .idx_i           (idx_q),
    .count_i         (count_q),
    .found_i         (found_q),
    .stale_timeout_i (stale_q),
    .retry_interval_i(retry_q),
    .entry_o         (head_entry),
    .res_o           (head_res)
  );

  assign final_ev = found_q ? ev_q : (head_res.announce ? EvFull : EvNone);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    found_d     = found_q;
    ev_d        = ev_q;
    req_d       = req_q;
    target_d    = target_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d  = StScan;
          idx_d    = '0;
          found_d  = 1'b0;
          ev_d     = EvNone;
          req_d    = 1'b0;
          target_d = 64'd0;
        end
      end
      StScan: begin
        if (head_res.hit) begin
          found_d  = 1'b1;
          ev_d     = head_res.ev;
          req_d    = head_res.request;
          target_d = head_res.target;
        end
        if (head_res.append) begin
          count_d = count_q + CntW'(1);
        end
        if (idx_q == IdxW'(MaxEntries - 1)) begin
          state_d = StDone;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.request_valid = req_q;
          out_d.target_id     = target_q;
          out_d.event_res     = final_ev;
          out_d.device_count  = 5'(count_q);
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      stale_q     <= StaleTimeoutRst;
      retry_q     <= RetryIntervalRst;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == RegStaleTimeout) begin
        stale_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == RegRetryInterval) begin
        retry_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q     <= ev_d;
    req_q    <= req_d;
    target_q <= target_d;
    out_q    <= out_d;
    if (in_acc) begin
      item_q <= in_item_i;
    end
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("entry count beyond table size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == $past(count_q) + CntW'(1))
    else $error("entry count jumped");

  a_req_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.request_valid |-> out_item_o.event_res == EvRequest)
    else $error("request without request event");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && idx_q == '0)
    else $error("scan did not start after accept");

endmodule

FILE: tb/device_presence_table_unit_tb.sv
module device_presence_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpt_pkg::*;

  localparam int DirRows   = 17;
  localparam int FillRows  = 14;
  localparam int Phases    = 8;
  localparam int PhaseLen  = 103;
  localparam logic [63:0] IdOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  dpt_in_t     in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  dpt_out_t    out_item_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = RegStaleTimeout;
  logic [31:0] cfg_data_i = '0;

  device_presence_table_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // own copy of the device table and its registers
  logic [63:0] seen_ids     [MaxEntries];
  logic [31:0] seen_pid     [MaxEntries];
  logic [31:0] last_seen_ms [MaxEntries];
  logic [31:0] last_req_ms  [MaxEntries];
  logic        pid_known    [MaxEntries];
  int          dev_count = 0;
  logic [31:0] stale_ms = StaleTimeoutRst;
  logic [31:0] retry_ms = RetryIntervalRst;

  dpt_out_t pending_results[$];
  logic     hand_typed = 1'b0;
  dpt_out_t hand_result = '0;
  dpt_out_t exp_res = '0;
  bit       idle_on = 1'b1;

  int items_taken = 0;
  int results_seen = 0;
  int err_cnt = 0;
  int cfg_writes = 0;
  int ev_cnt[8] = '{default: 0};

  logic [63:0] pool_ids[MaxEntries];

  function automatic dpt_out_t presence_step(input dpt_in_t it);
    dpt_out_t   r;
    dpt_event_e ev;
    logic       hit;
    logic [31:0] age_seen;
    logic [31:0] age_req;
    r = '0;
    ev = EvNone;
    hit = 1'b0;
    if (!it.action) begin
      if (!(it.frame_crc_low == 8'd0 && it.frame_len == 8'd0) && it.svc_idx == 8'd0) begin
        if (it.command == CmdAnnounce && it.device_id != 64'd0) begin
          for (int i = 0; i < dev_count; i++) begin
            if (!hit && seen_ids[i] == it.device_id) begin
              last_seen_ms[i] = it.now_ms;
              hit = 1'b1;
              ev = EvRefreshed;
            end
          end
          if (!hit) begin
            if (dev_count >= MaxEntries) begin
              ev = EvFull;
            end else begin
              seen_ids[dev_count] = it.device_id;
              seen_pid[dev_count] = '0;
              last_seen_ms[dev_count] = it.now_ms;
              last_req_ms[dev_count] = '0;
              pid_known[dev_count] = 1'b0;
              dev_count++;
              ev = EvAdded;
            end
          end
        end else if (it.command == CmdGetPid) begin
          for (int i = 0; i < dev_count; i++) begin
            if (!hit && seen_ids[i] == it.device_id) begin
              seen_pid[i] = it.product_id;
              pid_known[i] = 1'b1;
              last_seen_ms[i] = it.now_ms;
              hit = 1'b1;
              ev = EvPid;
            end
          end
        end
      end
    end else if (!it.rx_busy) begin
      for (int i = 0; i < dev_count; i++) begin
        age_seen = it.now_ms - last_seen_ms[i];
        age_req = it.now_ms - last_req_ms[i];
        if (!hit && !pid_known[i] && age_seen <= stale_ms && age_req >= retry_ms) begin
          last_req_ms[i] = it.now_ms;
          hit = 1'b1;
          r.request_valid = 1'b1;
          r.target_id = seen_ids[i];
          ev = EvRequest;
        end
      end
    end
    r.event_res = ev;
    r.device_count = 5'(dev_count);
    return r;
  endfunction

  function automatic dpt_in_t mk_item(input logic action, input logic [31:0] now,
                                      input logic [7:0] crc, input logic [7:0] size,
                                      input logic [63:0] id, input logic [7:0] svc,
                                      input logic [15:0] cmd, input logic [31:0] pid,
                                      input logic busy);
    dpt_in_t it;
    it.action = action;
    it.now_ms = now;
    it.frame_crc_low = crc;
    it.frame_len = size;
    it.device_id = id;
    it.svc_idx = svc;
    it.command = cmd;
    it.product_id = pid;
    it.rx_busy = busy;
    return it;
  endfunction

  function automatic dpt_out_t mk_res(input logic valid, input logic [63:0] target,
                                      input dpt_event_e ev, input int count);
    dpt_out_t r;
    r.request_valid = valid;
    r.target_id = target;
    r.event_res = ev;
    r.device_count = 5'(count);
    return r;
  endfunction

  // accepted items feed the predictor, accepted results are checked in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (hand_typed) begin
          void'(presence_step(in_item_i));
          pending_results.push_back(hand_result);
        end else begin
          pending_results.push_back(presence_step(in_item_i));
        end
        items_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        ev_cnt[out_item_o.event_res]++;
        if (pending_results.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected result: valid=%0b target=%h event=%0d count=%0d",
                     out_item_o.request_valid, out_item_o.target_id,
                     out_item_o.event_res, out_item_o.device_count);
          err_cnt++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_item_o.request_valid !== exp_res.request_valid ||
              out_item_o.target_id !== exp_res.target_id ||
              out_item_o.event_res !== exp_res.event_res ||
              out_item_o.device_count !== exp_res.device_count) begin
            if (err_cnt < 10)
              $display({"mismatch: exp valid=%0b target=%h event=%0d count=%0d,",
                        " got valid=%0b target=%h event=%0d count=%0d"},
                       exp_res.request_valid, exp_res.target_id,
                       exp_res.event_res, exp_res.device_count,
                       out_item_o.request_valid, out_item_o.target_id,
                       out_item_o.event_res, out_item_o.device_count);
            err_cnt++;
          end
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_item(input dpt_in_t it, input logic typed, input dpt_out_t res);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_item_i = it;
    hand_typed = typed;
    hand_result = res;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    if (idx == RegStaleTimeout) stale_ms = val;
    else retry_ms = val;
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // stop sending and wait for every expected result
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    hand_typed = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    dpt_in_t     dir_item[DirRows];
    logic        dir_typed[DirRows];
    dpt_out_t    dir_res[DirRows];
    dpt_in_t     it;
    logic [31:0] clock_ms;
    logic [31:0] new_stale;
    logic [31:0] new_retry;
    int          pick;
    int          jump;

    dir_typed = '{default: 1'b1};
    // empty table, empty frame, zero id, adds at the field extremes, refresh
    dir_item[0]  = mk_item(1'b1, 32'd0, 8'h00, 8'h00, 64'd0, 8'h00, 16'h0000, 32'd0, 1'b0);
    dir_res[0]   = mk_res(1'b0, 64'd0, EvNone, 0);
    dir_item[1]  = mk_item(1'b0, 32'd10, 8'h00, 8'h00, IdOnes, 8'h00, CmdAnnounce, 32'd0, 1'b0);
    dir_res[1]   = mk_res(1'b0, 64'd0, EvNone, 0);
    dir_item[2]  = mk_item(1'b0, 32'd15, 8'hFF, 8'h00, 64'd0, 8'h00, CmdAnnounce, 32'd0, 1'b0);
    dir_res[2]   = mk_res(1'b0, 64'd0, EvNone, 0);
    dir_item[3]  = mk_item(1'b0, 32'd20, 8'h00, 8'hFF, IdOnes, 8'h00, CmdAnnounce, 32'd0, 1'b0);
    dir_res[3]   = mk_res(1'b0, 64'd0, EvAdded, 1);
    dir_item[4]  = mk_item(1'b0, 32'd30, 8'h01, 8'h14, 64'd1, 8'h00, CmdAnnounce, 32'd0, 1'b0);
    dir_res[4]   = mk_res(1'b0, 64'd0, EvAdded, 2);
    dir_item[5]  = mk_item(1'b0, 32'd40, 8'hA5, 8'h14, IdOnes, 8'h00, CmdAnnounce, 32'd0, 1'b0);
    dir_res[5]   = mk_res(1'b0, 64'd0, EvRefreshed, 2);
    // foreign service, foreign command, reply from a stranger, busy poll
    dir_item[6]  = mk_item(1'b0, 32'd50, 8'h5A, 8'h14, 64'd1, 8'hFF, CmdAnnounce, 32'd0, 1'b0);
    dir_res[6]   = mk_res(1'b0, 64'd0, EvNone, 2);
    dir_item[7]  = mk_item(1'b0, 32'd60, 8'h5A, 8'h14, 64'd1, 8'h00, 16'hFFFF, 32'd0, 1'b0);
    dir_res[7]   = mk_res(1'b0, 64'd0, EvNone, 2);
    dir_item[8]  = mk_item(1'b0, 32'd70, 8'h5A, 8'h18, 64'h5555_5555_5555_5555, 8'h00,
                           CmdGetPid, 32'hFFFF_FFFF, 1'b0);
    dir_res[8]   = mk_res(1'b0, 64'd0, EvNone, 2);
    dir_item[9]  = mk_item(1'b1, 32'd500, 8'h00, 8'h00, 64'd0, 8'h00, 16'h0000, 32'd0, 1'b1);
    dir_res[9]   = mk_res(1'b0, 64'd0, EvNone, 2);
    // polls walk the retry interval, then the second entry goes stale
    dir_item[10] = mk_item(1'b1, 32'd600, 8'h00, 8'h00, 64'd0, 8'h00, 16'h0000, 32'd0, 1'b0);
    dir_typed[10] = 1'b0;
    dir_item[11] = mk_item(1'b1, 32'd700, 8'h00, 8'h00, 64'd0, 8'h00, 16'h0000, 32'd0, 1'b0);
    dir_typed[11] = 1'b0;
    dir_item[12] = mk_item(1'b1, 32'd800, 8'h00, 8'h00, 64'd0, 8'h00, 16'h0000, 32'd0, 1'b0);
    dir_typed[12] = 1'b0;
    dir_item[13] = mk_item(1'b0, 32'd900, 8'h33, 8'h18, IdOnes, 8'h00, CmdGetPid,
                           32'hFFFF_FFFF, 1'b0);
    dir_res[13]  = mk_res(1'b0, 64'd0, EvPid, 2);
    dir_item[14] = mk_item(1'b1, 32'd1300, 8'h00, 8'h00, 64'd0, 8'h00, 16'h0000, 32'd0, 1'b0);
    dir_typed[14] = 1'b0;
    dir_item[15] = mk_item(1'b1, 32'd9000, 8'h00, 8'h00, 64'd0, 8'h00, 16'h0000, 32'd0, 1'b0);
    dir_typed[15] = 1'b0;
    dir_item[16] = mk_item(1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, IdOnes, 8'hFF, 16'hFFFF,
                           32'hFFFF_FFFF, 1'b1);
    dir_res[16]  = mk_res(1'b0, 64'd0, EvNone, 2);

    pool_ids[0] = IdOnes;
    pool_ids[1] = 64'd1;
    for (int k = 0; k < FillRows; k++)
      pool_ids[k + 2] = {$urandom, 24'($urandom), 8'(k + 2)};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_cfg(RegStaleTimeout, StaleTimeoutRst);
    write_cfg(RegRetryInterval, RetryIntervalRst);

    for (int k = 0; k < DirRows; k++)
      send_item(dir_item[k], dir_typed[k], dir_res[k]);
    for (int k = 0; k < FillRows; k++)
      send_item(mk_item(1'b0, 32'd9100 + 32'(k), 8'h42, 8'h14, pool_ids[k + 2], 8'h00,
                        CmdAnnounce, 32'd0, 1'b0), 1'b0, '0);
    // one stranger too many
    send_item(mk_item(1'b0, 32'd9500, 8'h42, 8'h14, {$urandom, 24'($urandom), 8'h80}, 8'h00,
                      CmdAnnounce, 32'd0, 1'b0), 1'b1, mk_res(1'b0, 64'd0, EvFull, 16));

    clock_ms = 32'hFFFF_E000;
    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      case (ph)
        0: begin new_stale = 32'd0;          new_retry = 32'd0;          end
        1: begin new_stale = 32'hFFFF_FFFF;  new_retry = 32'd0;          end
        2: begin new_stale = 32'd2000;       new_retry = 32'hFFFF_FFFF;  end
        3: begin new_stale = StaleTimeoutRst; new_retry = RetryIntervalRst; end
        7: begin new_stale = 32'd3000;       new_retry = 32'd200;        end
        default: begin
          new_stale = $urandom_range(50, 8000);
          new_retry = $urandom_range(0, 1500);
        end
      endcase
      write_cfg(RegStaleTimeout, new_stale);
      write_cfg(RegRetryInterval, new_retry);
      idle_on = (ph != Phases - 1);
      for (int n = 0; n < PhaseLen; n++) begin
        jump = $urandom_range(0, 99);
        if (jump < 3) clock_ms = $urandom;
        else if (jump < 5) clock_ms += $urandom_range(0, 20000);
        else clock_ms += $urandom_range(0, 120);
        it = mk_item(1'b0, clock_ms, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                     8'($urandom), 16'($urandom), $urandom, 1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          it.action = 1'b1;
          it.rx_busy = ($urandom_range(0, 6) == 0);
        end else if (pick < 78) begin
          it.svc_idx = 8'h00;
          it.command = CmdAnnounce;
          if ($urandom_range(0, 32) == 0) begin
            it.frame_crc_low = 8'h00;
            it.frame_len = 8'h00;
          end
          jump = $urandom_range(0, 19);
          if (jump < 17) it.device_id = pool_ids[$urandom_range(0, MaxEntries - 1)];
          else if (jump == 19) it.device_id = 64'd0;
        end else if (pick < 82) begin
          it.svc_idx = 8'h00;
          it.command = CmdGetPid;
          if ($urandom_range(0, 1) == 0)
            it.device_id = pool_ids[$urandom_range(0, MaxEntries - 1)];
        end else begin
          if ($urandom_range(0, 1) == 0) it.svc_idx = 8'h00;
          if ($urandom_range(0, 2) == 0) it.command = CmdGetPid;
        end
        send_item(it, 1'b0, '0);
      end
    end

    settle();
    repeat (40) @(negedge clk_i);
    $display("%0d items and %0d results over %0d register writes, table ended with %0d devices",
             items_taken, results_seen, cfg_writes, dev_count);
    $display("events seen: %0d refresh, %0d add, %0d full, %0d pid, %0d request, %0d none",
             ev_cnt[EvRefreshed], ev_cnt[EvAdded], ev_cnt[EvFull], ev_cnt[EvPid],
             ev_cnt[EvRequest], ev_cnt[EvNone]);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("PASS device_presence_table_unit");
    end else begin
      $display("FAIL device_presence_table_unit");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL device_presence_table_unit");
    $finish;
  end

endmodule
